// File: rtl/smre_pkg.sv
// smre_pkg: shared types, codes and constants for the rendezvous engine
// depends on nothing
`timescale 1ns / 1ps
package smre_pkg;
	localparam int NPROC = 16;

	localparam logic [1:0] FN_SEND = 2'd0;
	localparam logic [1:0] FN_RECV = 2'd1;
	localparam logic [1:0] FN_POST = 2'd2;
	localparam logic [1:0] FN_BAD  = 2'd3;

	localparam logic [4:0] PEER_ANY = 5'd16;
	localparam logic [4:0] PEER_INT = 5'd17;
	localparam logic [4:0] NO_TASK  = 5'd18;
	localparam logic [4:0] LNK_NULL = 5'd16;

	localparam logic [2:0] ST_COPIED   = 3'd0;
	localparam logic [2:0] ST_NOTICE   = 3'd1;
	localparam logic [2:0] ST_BLOCKED  = 3'd2;
	localparam logic [2:0] ST_DEADLOCK = 3'd3;
	localparam logic [2:0] ST_INVALID  = 3'd4;
	localparam logic [2:0] ST_RECORDED = 3'd5;

	typedef struct packed {
		logic [1:0]  func;
		logic [3:0]  caller;
		logic [4:0]  peer;
		logic [31:0] buffer_addr;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  dest_proc;
		logic [31:0] dest_buffer;
		logic [3:0]  src_proc;
		logic [31:0] src_buffer;
	} rsp_t;

	// one process table entry
	typedef struct packed {
		logic        sending;
		logic        receiving;
		logic [4:0]  send_target;
		logic [4:0]  recv_source;
		logic [31:0] pending_buffer;
		logic        int_pending;
		logic [4:0]  queue_head;
		logic [4:0]  queue_link;
	} ent_t;

	localparam ent_t ENT_RST = '{sending: 1'b0, receiving: 1'b0, send_target: NO_TASK,
		recv_source: NO_TASK, pending_buffer: 32'd0, int_pending: 1'b0,
		queue_head: LNK_NULL, queue_link: LNK_NULL};

	// table port request from the sequencer
	typedef struct packed {
		logic       rd;
		logic [3:0] raddr;
		logic       wr;
		logic [3:0] waddr;
		ent_t       wdata;
	} tport_t;
endpackage

// File: rtl/smre_table.sv
// smre_table: process table memory, one read and one write port, valid bits per entry
// depends on smre_pkg
`timescale 1ns / 1ps
module smre_table (
	input  logic            clk,
	input  logic            arst_n,
	input  smre_pkg::tport_t port,
	output smre_pkg::ent_t   rdata
);
	import smre_pkg::*;

	ent_t            mem [NPROC];
	logic [NPROC-1:0] vld_q;
	logic            rvld_q;
	ent_t            rraw_q;

	// memory array, read data registered
	always_ff @(posedge clk) begin
		if (port.wr) begin
			mem[port.waddr] <= port.wdata;
		end
		if (port.rd) begin
			rraw_q <= mem[port.raddr];
		end
	end

	// valid bits, an unwritten entry reads as its reset value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (port.wr) begin
				vld_q[port.waddr] <= 1'b1;
			end
			if (port.rd) begin
				rvld_q <= vld_q[port.raddr];
			end
		end
	end

	assign rdata = rvld_q ? rraw_q : ENT_RST;
endmodule

// File: rtl/smre_seq.sv
// smre_seq: request sequencer, reads, modifies and writes back table entries
// depends on smre_pkg
`timescale 1ns / 1ps
module smre_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  smre_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output smre_pkg::rsp_t   rsp,
	output smre_pkg::tport_t port,
	input  smre_pkg::ent_t   rdata
);
	import smre_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RDC   = 4'd1;  // caller entry read in flight
	localparam logic [3:0] S_CALL  = 4'd2;  // caller entry available
	localparam logic [3:0] S_DLK   = 4'd3;  // deadlock walk
	localparam logic [3:0] S_PEER  = 4'd4;  // send peer entry available
	localparam logic [3:0] S_QHD   = 4'd5;  // send: peer entry for queue head
	localparam logic [3:0] S_QTL   = 4'd6;  // send: walk to tail
	localparam logic [3:0] S_RFROM = 4'd7;  // receive: sender entry
	localparam logic [3:0] S_RCAL  = 4'd8;  // receive: release of the matched sender
	localparam logic [3:0] S_RWLK  = 4'd9;  // receive: predecessor search
	localparam logic [3:0] S_OUT   = 4'd10;
	localparam logic [3:0] S_FIN   = 4'd11; // final write of the caller entry of a blocked send
	localparam logic [3:0] S_WAIT  = 4'd12; // wait state for an overlapping read

	logic [3:0]  st_q;
	req_t        r_q;
	ent_t        call_q;   // caller entry, kept up to date
	ent_t        from_q;   // matched sender entry
	logic [3:0]  p_q;      // walk pointer
	logic [4:0]  n_q;      // walk step count
	logic [3:0]  from_id_q;
	logic        rv_q;
	rsp_t        rsp_q;
	logic [3:0]  ret_q;

	assign req_ready = (st_q == S_IDLE) && !rv_q;
	assign rsp_valid = rv_q;
	assign rsp       = rsp_q;

	function automatic rsp_t mk(input logic [2:0] s);
		rsp_t o;
		o = '0;
		o.status = s;
		return o;
	endfunction

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			rv_q <= 1'b0;
			port <= '0;
		end else begin
			port.rd <= 1'b0;
			port.wr <= 1'b0;
			if (rv_q && rsp_ready) begin
				rv_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (req_valid && !rv_q) begin
						r_q <= req;
						if (req.func > FN_POST) begin
							rsp_q <= mk(ST_INVALID);
							rv_q  <= 1'b1;
						end else begin
							port.rd    <= 1'b1;
							port.raddr <= req.caller;
							st_q       <= S_RDC;
						end
					end
				end
				S_RDC: st_q <= S_CALL;
				S_CALL: begin
					call_q <= rdata;
					if (r_q.func == FN_POST) begin
						port.wr    <= 1'b1;
						port.waddr <= r_q.caller;
						port.wdata <= rdata;
						if (rdata.receiving && (rdata.recv_source == PEER_ANY ||
							rdata.recv_source == PEER_INT)) begin
							port.wdata.receiving      <= 1'b0;
							port.wdata.recv_source    <= NO_TASK;
							port.wdata.pending_buffer <= '0;
							rsp_q <= '{status: ST_NOTICE, dest_proc: r_q.caller,
								dest_buffer: rdata.pending_buffer, src_proc: '0,
								src_buffer: '0};
						end else begin
							port.wdata.int_pending <= 1'b1;
							rsp_q <= mk(ST_RECORDED);
						end
						st_q <= S_OUT;
					end else if (rdata.sending || rdata.receiving) begin
						rsp_q <= mk(ST_INVALID);
						st_q  <= S_OUT;
					end else if (r_q.func == FN_SEND) begin
						if (r_q.peer[4] || r_q.peer[3:0] == r_q.caller) begin
							rsp_q <= mk(ST_INVALID);
							st_q  <= S_OUT;
						end else begin
							port.rd    <= 1'b1;
							port.raddr <= r_q.peer[3:0];
							p_q        <= r_q.peer[3:0];
							n_q        <= '0;
							ret_q      <= S_DLK;
							st_q       <= S_WAIT;
						end
					end else begin
						// receive
						if (r_q.peer[3:0] == r_q.caller && !r_q.peer[4]) begin
							rsp_q <= mk(ST_INVALID);
							st_q  <= S_OUT;
						end else if (r_q.peer > PEER_INT) begin
							rsp_q <= mk(ST_INVALID);
							st_q  <= S_OUT;
						end else if (rdata.int_pending && (r_q.peer == PEER_ANY ||
							r_q.peer == PEER_INT)) begin
							port.wr    <= 1'b1;
							port.waddr <= r_q.caller;
							port.wdata <= rdata;
							port.wdata.int_pending <= 1'b0;
							rsp_q <= '{status: ST_NOTICE, dest_proc: r_q.caller,
								dest_buffer: r_q.buffer_addr, src_proc: '0,
								src_buffer: '0};
							st_q <= S_OUT;
						end else if ((r_q.peer == PEER_ANY && !rdata.queue_head[4]) ||
							!r_q.peer[4]) begin
							from_id_q  <= (r_q.peer == PEER_ANY) ? rdata.queue_head[3:0]
								: r_q.peer[3:0];
							port.rd    <= 1'b1;
							port.raddr <= (r_q.peer == PEER_ANY) ? rdata.queue_head[3:0]
								: r_q.peer[3:0];
							ret_q      <= S_RFROM;
							st_q       <= S_WAIT;
						end else begin
							port.wr    <= 1'b1;
							port.waddr <= r_q.caller;
							port.wdata <= rdata;
							port.wdata.receiving      <= 1'b1;
							port.wdata.recv_source    <= r_q.peer;
							port.wdata.pending_buffer <= r_q.buffer_addr;
							rsp_q <= mk(ST_BLOCKED);
							st_q  <= S_OUT;
						end
					end
				end
				S_WAIT: st_q <= ret_q;
				S_DLK: begin
					// rdata is entry p_q
					if (n_q == 5'(NPROC) || !rdata.sending) begin
						port.rd    <= 1'b1;
						port.raddr <= r_q.peer[3:0];
						ret_q      <= S_PEER;
						st_q       <= S_WAIT;
					end else if (rdata.send_target == {1'b0, r_q.caller}) begin
						rsp_q <= mk(ST_DEADLOCK);
						st_q  <= S_OUT;
					end else if (rdata.send_target[4]) begin
						port.rd    <= 1'b1;
						port.raddr <= r_q.peer[3:0];
						ret_q      <= S_PEER;
						st_q       <= S_WAIT;
					end else begin
						port.rd    <= 1'b1;
						port.raddr <= rdata.send_target[3:0];
						p_q        <= rdata.send_target[3:0];
						n_q        <= n_q + 5'd1;
						ret_q      <= S_DLK;
						st_q       <= S_WAIT;
					end
				end
				S_PEER: begin
					if (rdata.receiving && (rdata.recv_source == {1'b0, r_q.caller} ||
						rdata.recv_source == PEER_ANY)) begin
						port.wr    <= 1'b1;
						port.waddr <= r_q.peer[3:0];
						port.wdata <= rdata;
						port.wdata.receiving      <= 1'b0;
						port.wdata.recv_source    <= NO_TASK;
						port.wdata.pending_buffer <= '0;
						rsp_q <= '{status: ST_COPIED, dest_proc: r_q.peer[3:0],
							dest_buffer: rdata.pending_buffer, src_proc: r_q.caller,
							src_buffer: r_q.buffer_addr};
						st_q <= S_OUT;
					end else begin
						call_q.sending        <= 1'b1;
						call_q.send_target    <= r_q.peer;
						call_q.pending_buffer <= r_q.buffer_addr;
						call_q.queue_link     <= LNK_NULL;
						if (rdata.queue_head[4]) begin
							port.wr    <= 1'b1;
							port.waddr <= r_q.peer[3:0];
							port.wdata <= rdata;
							port.wdata.queue_head <= {1'b0, r_q.caller};
							from_id_q  <= r_q.caller;
							st_q       <= S_FIN;
						end else begin
							port.rd    <= 1'b1;
							port.raddr <= rdata.queue_head[3:0];
							p_q        <= rdata.queue_head[3:0];
							n_q        <= '0;
							ret_q      <= S_QTL;
							st_q       <= S_WAIT;
						end
					end
				end
				S_QTL: begin
					if (rdata.queue_link[4] || n_q == 5'(NPROC - 1)) begin
						port.wr    <= 1'b1;
						port.waddr <= p_q;
						port.wdata <= rdata;
						port.wdata.queue_link <= {1'b0, r_q.caller};
						st_q       <= S_FIN;
					end else begin
						port.rd    <= 1'b1;
						port.raddr <= rdata.queue_link[3:0];
						p_q        <= rdata.queue_link[3:0];
						n_q        <= n_q + 5'd1;
						ret_q      <= S_QTL;
						st_q       <= S_WAIT;
					end
				end
				S_FIN: begin
					// caller of a blocked send, now the tail of the peer's queue
					port.wr    <= 1'b1;
					port.waddr <= r_q.caller;
					port.wdata <= call_q;
					rsp_q <= mk(ST_BLOCKED);
					st_q  <= S_OUT;
				end
				S_RFROM: begin
					if (!r_q.peer[4] && !(rdata.sending &&
						rdata.send_target == {1'b0, r_q.caller})) begin
						port.wr    <= 1'b1;
						port.waddr <= r_q.caller;
						port.wdata <= call_q;
						port.wdata.receiving      <= 1'b1;
						port.wdata.recv_source    <= r_q.peer;
						port.wdata.pending_buffer <= r_q.buffer_addr;
						rsp_q <= mk(ST_BLOCKED);
						st_q  <= S_OUT;
					end else begin
						from_q <= rdata;
						rsp_q <= '{status: ST_COPIED, dest_proc: r_q.caller,
							dest_buffer: r_q.buffer_addr, src_proc: from_id_q,
							src_buffer: rdata.pending_buffer};
						if (call_q.queue_head == {1'b0, from_id_q}) begin
							port.wr    <= 1'b1;
							port.waddr <= r_q.caller;
							port.wdata <= call_q;
							port.wdata.queue_head <= rdata.queue_link;
							st_q <= S_RCAL;
						end else if (call_q.queue_head[4]) begin
							st_q <= S_RCAL;
						end else begin
							port.rd    <= 1'b1;
							port.raddr <= call_q.queue_head[3:0];
							p_q        <= call_q.queue_head[3:0];
							n_q        <= '0;
							ret_q      <= S_RWLK;
							st_q       <= S_WAIT;
						end
					end
				end
				S_RWLK: begin
					if (rdata.queue_link == {1'b0, from_id_q}) begin
						port.wr    <= 1'b1;
						port.waddr <= p_q;
						port.wdata <= rdata;
						port.wdata.queue_link <= from_q.queue_link;
						st_q <= S_RCAL;
					end else if (rdata.queue_link[4] || n_q == 5'(NPROC - 1)) begin
						st_q <= S_RCAL;
					end else begin
						port.rd    <= 1'b1;
						port.raddr <= rdata.queue_link[3:0];
						p_q        <= rdata.queue_link[3:0];
						n_q        <= n_q + 5'd1;
						ret_q      <= S_RWLK;
						st_q       <= S_WAIT;
					end
				end
				S_RCAL: begin
					// release the matched sender
					port.wr    <= 1'b1;
					port.waddr <= from_id_q;
					port.wdata <= from_q;
					port.wdata.queue_link     <= LNK_NULL;
					port.wdata.pending_buffer <= '0;
					port.wdata.send_target    <= NO_TASK;
					port.wdata.sending        <= 1'b0;
					st_q <= S_OUT;
				end
				S_OUT: begin
					rv_q <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/sync_message_rendezvous_engine_top.sv
// sync_message_rendezvous_engine_top: rendezvous engine, sequencer and process table
// handles one request at a time; a send may add deadlock and queue walks to a plain request
// each walk step is a registered table read followed by a wait state, bounded against NPROC
// a new request is taken only once the previous response has been accepted
// asynchronous active-low reset empties the table at once through per-entry valid bits
// depends on smre_pkg, smre_seq, smre_table
`timescale 1ns / 1ps
module sync_message_rendezvous_engine_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  smre_pkg::req_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output smre_pkg::rsp_t out_data
);
	import smre_pkg::*;

	tport_t port;
	ent_t   rdata;

	// request sequencer
	smre_seq u_seq (
		.clk(clk), .arst_n(arst_n),
		.req_valid(in_valid), .req_ready(in_ready), .req(in_data),
		.rsp_valid(out_valid), .rsp_ready(out_ready), .rsp(out_data),
		.port(port), .rdata(rdata)
	);

	// process table
	smre_table u_tbl (.clk(clk), .arst_n(arst_n), .port(port), .rdata(rdata));
endmodule

// File: dv/tb_sync_message_rendezvous_engine_top.sv
// tb_sync_message_rendezvous_engine_top: self-checking bench for the rendezvous engine
// directed table then random traffic, checked against a behavioural process table
// depends on smre_pkg and sync_message_rendezvous_engine_top
`timescale 1ns / 1ps
module tb_sync_message_rendezvous_engine_top;
	import smre_pkg::*;

	localparam int N_RANDOM = 1730;
	localparam int WD_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rsp_t out_data;

	always #5 clk = ~clk;

	sync_message_rendezvous_engine_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// behavioural process table
	logic        m_snd [NPROC];
	logic        m_rcv [NPROC];
	logic [4:0]  m_tgt [NPROC];
	logic [4:0]  m_src [NPROC];
	logic [31:0] m_buf [NPROC];
	logic        m_int [NPROC];
	logic [4:0]  m_head [NPROC];
	logic [4:0]  m_link [NPROC];

	rsp_t rsp_queue[$];
	int   n_errors = 0;
	int   n_words = 0;
	int   n_seen = 0;
	int   st_count[8];
	bit   stim_done = 1'b0;
	bit   hold_long = 1'b0;

	function automatic rsp_t mk(logic [2:0] st, logic [3:0] dp = '0, logic [31:0] db = '0,
		logic [3:0] sp = '0, logic [31:0] sb = '0);
		rsp_t r;
		r.status = st; r.dest_proc = dp; r.dest_buffer = db;
		r.src_proc = sp; r.src_buffer = sb;
		return r;
	endfunction

	function automatic bit chain_closes(int who, int dst);
		int p;
		p = dst;
		for (int n = 0; n < NPROC; n++) begin
			if (p >= NPROC || !m_snd[p]) return 1'b0;
			if (m_tgt[p] == who) return 1'b1;
			p = m_tgt[p];
		end
		return 1'b0;
	endfunction

	function automatic void enqueue_sender(int dst, int who);
		int p;
		p = m_head[dst];
		m_link[who] = LNK_NULL;
		if (p >= NPROC) begin
			m_head[dst] = 5'(who);
			return;
		end
		for (int n = 0; n < NPROC; n++) begin
			if (m_link[p] >= NPROC) break;
			p = m_link[p];
		end
		m_link[p] = 5'(who);
	endfunction

	function automatic void dequeue_sender(int owner, int who);
		int p;
		p = m_head[owner];
		if (p == who) m_head[owner] = m_link[who];
		else begin
			for (int n = 0; n < NPROC && p < NPROC; n++) begin
				if (m_link[p] == who) begin
					m_link[p] = m_link[who];
					break;
				end
				p = m_link[p];
			end
		end
		m_link[who] = LNK_NULL;
	endfunction

	function automatic void table_reset();
		for (int i = 0; i < NPROC; i++) begin
			m_snd[i] = 1'b0; m_rcv[i] = 1'b0; m_tgt[i] = NO_TASK; m_src[i] = NO_TASK;
			m_buf[i] = '0; m_int[i] = 1'b0; m_head[i] = LNK_NULL; m_link[i] = LNK_NULL;
		end
	endfunction

	// rendezvous decision for one request
	function automatic rsp_t rendezvous(req_t q);
		int c, pr, from;
		logic [31:0] b;
		c = q.caller; pr = q.peer; b = q.buffer_addr; from = LNK_NULL;
		if (q.func > FN_POST) return mk(ST_INVALID);
		if (q.func == FN_POST) begin
			if (m_rcv[c] && (m_src[c] == PEER_ANY || m_src[c] == PEER_INT)) begin
				b = m_buf[c];
				m_rcv[c] = 1'b0; m_src[c] = NO_TASK; m_buf[c] = '0;
				return mk(ST_NOTICE, 4'(c), b);
			end
			m_int[c] = 1'b1;
			return mk(ST_RECORDED);
		end
		if (m_snd[c] || m_rcv[c]) return mk(ST_INVALID);
		if (q.func == FN_SEND) begin
			if (pr >= NPROC || pr == c) return mk(ST_INVALID);
			if (chain_closes(c, pr)) return mk(ST_DEADLOCK);
			if (m_rcv[pr] && (m_src[pr] == c || m_src[pr] == PEER_ANY)) begin
				logic [31:0] db;
				db = m_buf[pr];
				m_rcv[pr] = 1'b0; m_src[pr] = NO_TASK; m_buf[pr] = '0;
				return mk(ST_COPIED, 4'(pr), db, 4'(c), b);
			end
			m_snd[c] = 1'b1; m_tgt[c] = 5'(pr); m_buf[c] = b;
			enqueue_sender(pr, c);
			return mk(ST_BLOCKED);
		end
		if (pr == c || pr > PEER_INT) return mk(ST_INVALID);
		if (m_int[c] && (pr == PEER_ANY || pr == PEER_INT)) begin
			m_int[c] = 1'b0;
			return mk(ST_NOTICE, 4'(c), b);
		end
		if (pr == PEER_ANY) begin
			if (m_head[c] < NPROC) from = m_head[c];
		end else if (pr < NPROC) begin
			if (m_snd[pr] && m_tgt[pr] == c) from = pr;
		end
		if (from < NPROC) begin
			logic [31:0] sb;
			sb = m_buf[from];
			dequeue_sender(c, from);
			m_buf[from] = '0; m_tgt[from] = NO_TASK; m_snd[from] = 1'b0;
			return mk(ST_COPIED, 4'(c), b, 4'(from), sb);
		end
		m_rcv[c] = 1'b1; m_src[c] = 5'(pr); m_buf[c] = b;
		return mk(ST_BLOCKED);
	endfunction

	// directed stimulus; expected result typed in where obvious
	typedef struct {
		req_t q;
		bit   fixed;
		rsp_t r;
	} dir_row_t;

	function automatic req_t rq(logic [1:0] f, logic [3:0] c, logic [4:0] p, logic [31:0] b);
		req_t q;
		q.func = f; q.caller = c; q.peer = p; q.buffer_addr = b;
		return q;
	endfunction

	dir_row_t dir_rows[$];

	initial begin
		table_reset();
		dir_rows = '{
			'{rq(FN_BAD, 4'd0, 5'd0, 32'hFFFF_FFFF), 1, mk(ST_INVALID)},
			'{rq(FN_SEND, 4'd3, 5'd3, 32'h1), 1, mk(ST_INVALID)},
			'{rq(FN_SEND, 4'd3, PEER_ANY, 32'h1), 1, mk(ST_INVALID)},
			'{rq(FN_SEND, 4'd3, 5'd31, 32'h1), 1, mk(ST_INVALID)},
			'{rq(FN_RECV, 4'd5, 5'd5, 32'h1), 1, mk(ST_INVALID)},
			'{rq(FN_RECV, 4'd5, 5'd18, 32'h1), 1, mk(ST_INVALID)},
			'{rq(FN_RECV, 4'd15, PEER_ANY, 32'hFFFF_FFFF), 1, mk(ST_BLOCKED)},
			'{rq(FN_SEND, 4'd0, 5'd15, 32'hA5A5_5A5A), 1,
				mk(ST_COPIED, 4'd15, 32'hFFFF_FFFF, 4'd0, 32'hA5A5_5A5A)},
			'{rq(FN_SEND, 4'd1, 5'd2, 32'h0), 1, mk(ST_BLOCKED)},
			'{rq(FN_SEND, 4'd1, 5'd3, 32'h0), 1, mk(ST_INVALID)},
			'{rq(FN_SEND, 4'd2, 5'd1, 32'h0), 1, mk(ST_DEADLOCK)},
			'{rq(FN_SEND, 4'd4, 5'd2, 32'h44), 0, '0},
			'{rq(FN_SEND, 4'd3, 5'd1, 32'h33), 0, '0},
			'{rq(FN_SEND, 4'd2, 5'd3, 32'h22), 1, mk(ST_DEADLOCK)},
			'{rq(FN_RECV, 4'd2, 5'd4, 32'h20), 0, '0},
			'{rq(FN_RECV, 4'd2, PEER_ANY, 32'h21), 0, '0},
			'{rq(FN_RECV, 4'd6, PEER_INT, 32'h60), 1, mk(ST_BLOCKED)},
			'{rq(FN_SEND, 4'd7, 5'd6, 32'h70), 1, mk(ST_BLOCKED)},
			'{rq(FN_POST, 4'd6, 5'd31, 32'hFFFF_FFFF), 1, mk(ST_NOTICE, 4'd6, 32'h60)},
			'{rq(FN_POST, 4'd8, 5'd0, 32'h0), 1, mk(ST_RECORDED)},
			'{rq(FN_RECV, 4'd8, 5'd9, 32'h80), 1, mk(ST_BLOCKED)},
			'{rq(FN_POST, 4'd9, 5'd0, 32'h0), 1, mk(ST_RECORDED)},
			'{rq(FN_RECV, 4'd9, PEER_INT, 32'h90), 1, mk(ST_NOTICE, 4'd9, 32'h90)},
			'{rq(FN_RECV, 4'd6, 5'd7, 32'h61), 0, '0},
			'{rq(FN_SEND, 4'd9, 5'd8, 32'h91), 0, '0}
		};
	end

	function automatic req_t random_word();
		req_t q;
		int k;
		q.buffer_addr = $urandom;
		k = $urandom_range(0, 99);
		q.caller = 4'($urandom_range(0, 15));
		q.peer = 5'($urandom_range(0, 15));
		if (k < 45) begin
			q.func = FN_SEND;
		end else if (k < 85) begin
			q.func = FN_RECV;
			if ($urandom_range(0, 3) == 0)
				q.peer = ($urandom_range(0, 1) == 0) ? PEER_ANY : PEER_INT;
		end else if (k < 95) q.func = FN_POST;
		else q.func = FN_BAD;
		if (k >= 85 || $urandom_range(0, 19) == 0) q.peer = 5'($urandom_range(0, 31));
		return q;
	endfunction

	// valid drops only when a gap is drawn
	task automatic send_word(req_t q);
		int gap;
		gap = $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= q;
		do @(posedge clk); while (!in_ready);
		n_words++;
	endtask

	// sender
	initial begin
		rsp_t r;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) begin
			r = rendezvous(dir_rows[i].q);
			if (dir_rows[i].fixed && r !== dir_rows[i].r) begin
				$error("directed row %0d: table entry %h disagrees with predictor %h",
					i, dir_rows[i].r, r);
				n_errors++;
			end
			rsp_queue.push_back(r);
			send_word(dir_rows[i].q);
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			req_t q;
			q = random_word();
			rsp_queue.push_back(rendezvous(q));
			if (i == 400) hold_long = 1'b1;
			send_word(q);
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// receiver with random stalls and one long hold-off
	initial begin
		forever begin
			@(posedge clk);
			if (hold_long) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_long = 1'b0;
			end
			if (out_valid && out_ready) out_ready <= 1'b0;
			else if (!out_ready) begin
				repeat ($urandom_range(0, 11)) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	// response checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			rsp_t e;
			n_seen++;
			if (rsp_queue.size() == 0) begin
				$error("unexpected response %h", out_data);
				n_errors++;
			end else begin
				e = rsp_queue.pop_front();
				st_count[e.status]++;
				if (out_data.status !== e.status) begin
					$error("status: expected %0d got %0d", e.status, out_data.status);
					n_errors++;
				end
				if (out_data.dest_proc !== e.dest_proc) begin
					$error("dest_proc: expected %0d got %0d", e.dest_proc, out_data.dest_proc);
					n_errors++;
				end
				if (out_data.dest_buffer !== e.dest_buffer) begin
					$error("dest_buffer: expected %h got %h", e.dest_buffer,
						out_data.dest_buffer);
					n_errors++;
				end
				if (out_data.src_proc !== e.src_proc) begin
					$error("src_proc: expected %0d got %0d", e.src_proc, out_data.src_proc);
					n_errors++;
				end
				if (out_data.src_buffer !== e.src_buffer) begin
					$error("src_buffer: expected %h got %h", e.src_buffer,
						out_data.src_buffer);
					n_errors++;
				end
			end
		end
	end

	// watchdog and end of run
	initial begin
		int idle;
		idle = 0;
		@(posedge arst_n);
		while (!(stim_done && rsp_queue.size() == 0) && idle < WD_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
			else idle++;
		end
		if (idle >= WD_LIMIT) begin
			$display("timeout with %0d responses outstanding", rsp_queue.size());
			$display("simulation failed");
			$finish;
		end else begin
			repeat (100) @(posedge clk);
			$display("%0d requests, %0d responses checked", n_words, n_seen);
			$display("copied %0d notice %0d blocked %0d deadlock %0d invalid %0d recorded %0d",
				st_count[ST_COPIED], st_count[ST_NOTICE], st_count[ST_BLOCKED],
				st_count[ST_DEADLOCK], st_count[ST_INVALID], st_count[ST_RECORDED]);
			if (n_errors == 0) $display("simulation ok");
			else $display("simulation failed");
			$finish;
		end
	end
endmodule

// File: filelist.f
rtl/smre_pkg.sv
rtl/smre_table.sv
rtl/smre_seq.sv
rtl/sync_message_rendezvous_engine_top.sv
dv/tb_sync_message_rendezvous_engine_top.sv
